>>> rtl/ipcp_pkg.sv
package ipcp_pkg;

    localparam int DUTY_BITS  = 8;
    localparam int ANGLE_BITS = 16;

    localparam int QB   = ANGLE_BITS - 2;
    localparam int UP   = (QB <= 16) ? (16 - QB) : 0;
    localparam int DN   = (QB > 16) ? (QB - 16) : 0;
    localparam int GX_W = QB + UP + 1;

    localparam int NUM_W    = 32 + DUTY_BITS;
    localparam int TRIG_STG = 4;
    localparam int XF_STG   = 3;
    localparam int NSTG     = TRIG_STG + XF_STG + DUTY_BITS;

    localparam logic [QB:0]           QUARTER  = (QB + 1)'(1) << QB;
    localparam logic [16:0]           SIN_A    = 17'd102944;
    localparam logic [15:0]           SIN_B    = 16'd42047;
    localparam logic [12:0]           SIN_C    = 13'd4640;
    localparam logic [17:0]           SQRT3X2  = 18'd227024;
    localparam logic [14:0]           Q15_MAX  = 15'h7fff;
    localparam logic [DUTY_BITS-1:0]  DUTY_MAX = '1;
    localparam logic [15:0]           SUPPLY_RESET = 16'd12000;

    localparam logic [1:0] ADDR_SUPPLY = 2'd0;

    function automatic logic [16:0] f_to_q16(input logic [QB:0] g);
        logic [GX_W-1:0] wide;
        wide = GX_W'(g) << UP;
        return 17'(wide >> DN);
    endfunction

endpackage

>>> rtl/ipcp_trig.sv
module ipcp_trig
    import ipcp_pkg::*;
(
    input  logic                i_clk,
    input  logic [TRIG_STG-1:0] i_en,
    input  logic signed [15:0]  i_quad_voltage,
    input  logic [15:0]         i_elec_angle,
    input  logic [15:0]         i_supply,
    output logic signed [16:0]  o_q2,
    output logic signed [15:0]  o_sin,
    output logic signed [15:0]  o_cos
);

    logic [ANGLE_BITS-1:0] phase;
    logic [1:0]            quad [2];
    logic [QB-1:0]         frac;

    logic signed [17:0] q2w;
    logic signed [17:0] sups;
    logic signed [17:0] q2c;

    logic signed [16:0] r_q2 [TRIG_STG];

    logic [16:0]        r_z1  [2];
    logic [16:0]        r_zz1 [2];
    logic               r_ng1 [2];
    logic [15:0]        r_t2  [2];
    logic [16:0]        r_z2  [2];
    logic [16:0]        r_zz2 [2];
    logic               r_ng2 [2];
    logic [16:0]        r_u3  [2];
    logic [16:0]        r_z3  [2];
    logic               r_ng3 [2];
    logic signed [15:0] r_sc4 [2];

    assign phase   = ANGLE_BITS'(i_elec_angle);
    assign frac    = phase[QB-1:0];
    assign quad[0] = phase[ANGLE_BITS-1 -: 2];
    assign quad[1] = quad[0] + 2'd1;

    always_comb begin
        q2w  = {i_quad_voltage[15], i_quad_voltage, 1'b0};
        sups = $signed({2'b00, i_supply});
        if (q2w > sups) begin
            q2c = sups;
        end else if (q2w < -sups) begin
            q2c = -sups;
        end else begin
            q2c = q2w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q2[0] <= q2c[16:0];
        end
        for (int k = 1; k < TRIG_STG; k++) begin
            if (i_en[k]) begin
                r_q2[k] <= r_q2[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [QB:0]   g;
        logic [16:0]   z;
        logic [33:0]   zz;
        logic [29:0]   cz;
        logic [15:0]   t;
        logic [32:0]   tz;
        logic [16:0]   u;
        logic [33:0]   p;
        logic [17:0]   rnd;
        logic [14:0]   mag;
        logic signed [15:0] sc;

        always_comb begin
            g   = quad[l][0] ? (QUARTER - {1'b0, frac}) : {1'b0, frac};
            z   = f_to_q16(g);
            zz  = 34'(z) * 34'(z);
            cz  = 30'(SIN_C) * 30'(r_zz1[l]);
            t   = SIN_B - 16'(cz[29:16]);
            tz  = 33'(r_t2[l]) * 33'(r_zz2[l]);
            u   = SIN_A - 17'(tz[32:16]);
            p   = 34'(r_u3[l]) * 34'(r_z3[l]);
            rnd = (18'(p[33:16]) + 18'd1) >> 1;
            mag = (rnd > 18'(Q15_MAX)) ? Q15_MAX : rnd[14:0];
            sc  = r_ng3[l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_z1[l]  <= z;
                r_zz1[l] <= zz[32:16];
                r_ng1[l] <= quad[l][1];
            end
            if (i_en[1]) begin
                r_t2[l]  <= t;
                r_z2[l]  <= r_z1[l];
                r_zz2[l] <= r_zz1[l];
                r_ng2[l] <= r_ng1[l];
            end
            if (i_en[2]) begin
                r_u3[l]  <= u;
                r_z3[l]  <= r_z2[l];
                r_ng3[l] <= r_ng2[l];
            end
            if (i_en[3]) begin
                r_sc4[l] <= sc;
            end
        end
    end

    assign o_q2  = r_q2[TRIG_STG-1];
    assign o_sin = r_sc4[0];
    assign o_cos = r_sc4[1];

endmodule

>>> rtl/ipcp_xform.sv
module ipcp_xform
    import ipcp_pkg::*;
(
    input  logic               i_clk,
    input  logic [XF_STG-1:0]  i_en,
    input  logic [15:0]        i_supply,
    input  logic signed [16:0] i_q2,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    output logic [NUM_W-1:0]   o_num_a,
    output logic [NUM_W-1:0]   o_num_b,
    output logic [NUM_W-1:0]   o_num_c
);

    logic signed [32:0] pa;
    logic signed [32:0] pb;
    logic signed [32:0] r_a;
    logic signed [32:0] r_b;

    logic signed [51:0] bias;
    logic signed [51:0] full;
    logic signed [51:0] mb;
    logic signed [51:0] ash16;
    logic signed [51:0] ash17;
    logic signed [51:0] n_v [3];
    logic signed [51:0] r_v [3];

    logic [NUM_W-1:0] n_num [3];
    logic [NUM_W-1:0] r_num [3];

    always_comb begin
        pa    = 33'(i_q2) * 33'(i_sin);
        pb    = 33'(i_q2) * 33'(i_cos);
        bias  = $signed(52'({i_supply, 32'b0}));
        full  = $signed(52'({i_supply, 33'b0}));
        mb    = 52'($signed({1'b0, SQRT3X2})) * 52'(r_b);
        ash16 = 52'(r_a) <<< 16;
        ash17 = 52'(r_a) <<< 17;
        n_v[0] = ash17 + bias;
        n_v[1] = mb - ash16 + bias;
        n_v[2] = -ash16 - mb + bias;
    end

    for (genvar l = 0; l < 3; l++) begin : g_phase
        logic signed [51:0] vc;
        always_comb begin
            if (r_v[l] < 0) begin
                vc = '0;
            end else if (r_v[l] > full) begin
                vc = full;
            end else begin
                vc = r_v[l];
            end
            n_num[l] = NUM_W'(vc[48:17]) * NUM_W'(DUTY_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a <= -pa;
            r_b <= pb;
        end
        if (i_en[1]) begin
            r_v <= n_v;
        end
        if (i_en[2]) begin
            r_num <= n_num;
        end
    end

    assign o_num_a = r_num[0];
    assign o_num_b = r_num[1];
    assign o_num_c = r_num[2];

endmodule

>>> rtl/ipcp_div.sv
module ipcp_div
    import ipcp_pkg::*;
(
    input  logic                 i_clk,
    input  logic [DUTY_BITS-1:0] i_en,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [31:0]          i_den,
    output logic [DUTY_BITS-1:0] o_duty
);

    logic [NUM_W-1:0]     rem_in [DUTY_BITS];
    logic [DUTY_BITS-1:0] quo_in [DUTY_BITS];
    logic [NUM_W-1:0]     n_rem  [DUTY_BITS];
    logic [DUTY_BITS-1:0] n_quo  [DUTY_BITS];
    logic [NUM_W-1:0]     r_rem  [DUTY_BITS];
    logic [DUTY_BITS-1:0] r_quo  [DUTY_BITS];

    assign rem_in[0] = i_num;
    assign quo_in[0] = '0;

    for (genvar i = 0; i < DUTY_BITS; i++) begin : g_step
        localparam int K = DUTY_BITS - 1 - i;
        logic [NUM_W-1:0] dsh;
        logic             ge;

        if (i > 0) begin : g_link
            assign rem_in[i] = r_rem[i-1];
            assign quo_in[i] = r_quo[i-1];
        end

        always_comb begin
            dsh      = NUM_W'(i_den) << K;
            ge       = (rem_in[i] >= dsh);
            n_rem[i] = ge ? (rem_in[i] - dsh) : rem_in[i];
            n_quo[i] = quo_in[i];
            n_quo[i][K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
            end
        end
    end

    assign o_duty = r_quo[DUTY_BITS-1];

endmodule

>>> rtl/inverse_park_clarke_pwm_unit.sv
// Stages from input beat to result beat:
// four sine/cosine polynomial stages, three transform stages, one divider step per duty bit.
// Throughput: one beat per cycle; a held output stalls only stages that are full.
// Reset (synchronous, active low): pipeline emptied, supply register set to 12000 mV.
module inverse_park_clarke_pwm_unit
    import ipcp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_quad_voltage,
    input  logic [15:0]          i_elec_angle,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DUTY_BITS-1:0] o_duty_a,
    output logic [DUTY_BITS-1:0] o_duty_b,
    output logic [DUTY_BITS-1:0] o_duty_c,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [15:0]     r_supply;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   en;

    logic signed [16:0] q2;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic [NUM_W-1:0]   num_a;
    logic [NUM_W-1:0]   num_b;
    logic [NUM_W-1:0]   num_c;
    logic [31:0]        den;
    logic [DUTY_BITS-1:0] qa;
    logic [DUTY_BITS-1:0] qb;
    logic [DUTY_BITS-1:0] qc;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SUPPLY) ? 32'(r_supply) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_SUPPLY)) begin
            r_supply <= pwdata[15:0];
        end
    end

    // advance a stage when it is empty or the next one advances
    always_comb begin
        en[NSTG] = !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NSTG-1];
    assign den     = {r_supply, 16'b0};

    ipcp_trig u_trig (
        .i_clk          (i_clk),
        .i_en           (en[TRIG_STG-1:0]),
        .i_quad_voltage (i_quad_voltage),
        .i_elec_angle   (i_elec_angle),
        .i_supply       (r_supply),
        .o_q2           (q2),
        .o_sin          (sn),
        .o_cos          (cs)
    );

    ipcp_xform u_xform (
        .i_clk    (i_clk),
        .i_en     (en[TRIG_STG+XF_STG-1:TRIG_STG]),
        .i_supply (r_supply),
        .i_q2     (q2),
        .i_sin    (sn),
        .i_cos    (cs),
        .o_num_a  (num_a),
        .o_num_b  (num_b),
        .o_num_c  (num_c)
    );

    ipcp_div u_div_a (
        .i_clk  (i_clk),
        .i_en   (en[NSTG-1:TRIG_STG+XF_STG]),
        .i_num  (num_a),
        .i_den  (den),
        .o_duty (qa)
    );

    ipcp_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (en[NSTG-1:TRIG_STG+XF_STG]),
        .i_num  (num_b),
        .i_den  (den),
        .o_duty (qb)
    );

    ipcp_div u_div_c (
        .i_clk  (i_clk),
        .i_en   (en[NSTG-1:TRIG_STG+XF_STG]),
        .i_num  (num_c),
        .i_den  (den),
        .o_duty (qc)
    );

    // zero supply forces zero duty
    assign o_duty_a = (r_supply == '0) ? '0 : qa;
    assign o_duty_b = (r_supply == '0) ? '0 : qb;
    assign o_duty_c = (r_supply == '0) ? '0 : qc;

endmodule

>>> rtl/ipcp_chk.sv
module ipcp_chk
    import ipcp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_stall,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic [DUTY_BITS-1:0] o_duty_a,
    input logic [DUTY_BITS-1:0] o_duty_b,
    input logic [DUTY_BITS-1:0] o_duty_c
);

    a_stall_needs_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)
    ) else $error("input stalled while output side can advance");

    a_empty_after_reset : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid
    ) else $error("result beat right after reset");

    a_hold_result : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_duty_a) && $stable(o_duty_b) && $stable(o_duty_c))
    ) else $error("stalled result beat changed");

endmodule

bind inverse_park_clarke_pwm_unit ipcp_chk u_chk (.*);
